/* design/hcdr_pkg.sv */
// ----------------------------------------------------------------------------
// hcdr_pkg
// Shared types, constants and commutation tables for the hall commutation
// and duty ramp block.
// ----------------------------------------------------------------------------
package hcdr_pkg;

  localparam int DUTY_OUT_W  = 12;
  localparam int TARGET_W    = 12;
  localparam int SPEED_W     = 16;
  localparam int COMP_W      = 12;
  localparam int RATIO_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CNT_W       = 9;

  localparam int RESTRICT_STEP = 3;

  typedef logic [2:0] hall_t;
  typedef logic [1:0] phase_t;
  typedef logic [5:0] gates_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam phase_t PHASE_A    = 2'd0;
  localparam phase_t PHASE_B    = 2'd1;
  localparam phase_t PHASE_C    = 2'd2;
  localparam phase_t PHASE_NONE = 2'd3;

  localparam hall_t HALL_ALL_LOW  = 3'd0;
  localparam hall_t HALL_ALL_HIGH = 3'd7;

  localparam cfg_index_t REG_ADD_INTERVAL = 3'd0;
  localparam cfg_index_t REG_SUB_INTERVAL = 3'd1;
  localparam cfg_index_t REG_DUTY_UPPER   = 3'd2;
  localparam cfg_index_t REG_DUTY_LOWER   = 3'd3;
  localparam cfg_index_t REG_SPEED_GAIN   = 3'd4;
  localparam cfg_index_t REG_DUTY_OFFSET  = 3'd5;
  localparam cfg_index_t REG_BUS_RATIO    = 3'd6;

  localparam logic [7:0]         ADD_INTERVAL_RST = 8'd12;
  localparam logic [7:0]         SUB_INTERVAL_RST = 8'd12;
  localparam logic [11:0]        DUTY_UPPER_RST   = 12'd1250;
  localparam logic [11:0]        DUTY_LOWER_RST   = 12'd0;
  localparam logic [15:0]        SPEED_GAIN_RST   = 16'd0;
  localparam logic signed [12:0] DUTY_OFFSET_RST  = 13'sd0;
  localparam logic [15:0]        BUS_RATIO_RST    = 16'd26018;

  // high side phase, low side phase and legal predecessor per hall code
  localparam phase_t HI_OF [8] = '{2'd3, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3};
  localparam phase_t LO_OF [8] = '{2'd3, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1, 2'd3};
  localparam hall_t PRED_OF [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};

  typedef struct packed {
    logic [7:0]         add_interval;
    logic [7:0]         sub_interval;
    logic [11:0]        duty_upper;
    logic [11:0]        duty_lower;
    logic [15:0]        speed_gain;
    logic signed [12:0] duty_offset;
    logic [15:0]        bus_ratio;
  } cfg_t;

  typedef struct packed {
    logic [TARGET_W-1:0]       target;
    logic signed [SPEED_W-1:0] speed;
    logic                      restrict_on;
    logic signed [COMP_W-1:0]  comp;
  } ramp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ramp_stat_t;

  function automatic gates_t gate_pattern(phase_t hp, phase_t lp);
    gates_t g;
    g = '0;
    case (hp)
      PHASE_A: g[5] = 1'b1;
      PHASE_B: g[3] = 1'b1;
      PHASE_C: g[1] = 1'b1;
      default: ;
    endcase
    case (lp)
      PHASE_A: g[4] = 1'b1;
      PHASE_B: g[2] = 1'b1;
      PHASE_C: g[0] = 1'b1;
      default: ;
    endcase
    return g;
  endfunction

endpackage

/* design/hcdr_serial_mul.sv */
// ----------------------------------------------------------------------------
// hcdr_serial_mul
// Radix-4 serial multiplier: signed multiplicand times unsigned multiplier,
// two multiplier bits per cycle, product bits shifted out low end first.
// ----------------------------------------------------------------------------
module hcdr_serial_mul import hcdr_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic                 done,
  output logic signed [AW+BW-1:0] product
);

  localparam int STEPS = BW / 2;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int HW    = AW + 3;

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  a_q;
  logic [AW+1:0]  a3_q;
  logic [BW-1:0]  b_sh;
  logic [HW-1:0]  hi;
  logic [BW-1:0]  lo;
  logic [HW-1:0]  part;
  logic [HW-1:0]  acc;

  always_comb begin
    case (b_sh[1:0])
      2'd1:    part = {{3{a_q[AW-1]}}, a_q};
      2'd2:    part = {{2{a_q[AW-1]}}, a_q, 1'b0};
      2'd3:    part = {a3_q[AW+1], a3_q};
      default: part = '0;
    endcase
    acc = hi + part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      a3_q <= {a[AW-1], a[AW-1], a} + {a[AW-1], a, 1'b0};
      b_sh <= b;
      hi   <= '0;
    end else if (busy) begin
      hi   <= {{2{acc[HW-1]}}, acc[HW-1:2]};
      lo   <= {acc[1:0], lo[BW-1:2]};
      b_sh <= {2'b00, b_sh[BW-1:2]};
    end
  end

  assign product = {hi[AW-1:0], lo};

endmodule

/* design/hcdr_ramp.sv */
// ----------------------------------------------------------------------------
// hcdr_ramp
// Duty ramp sequencer: maximum-duty line through the shared serial
// multiplier (not in restrict mode), then restrict / step / clamp duty update.
// ----------------------------------------------------------------------------
module hcdr_ramp import hcdr_pkg::*; #(
  parameter int DUTY_WIDTH  = 12,
  parameter int SPEED_LIMIT = 6000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  start,
  input  ramp_req_t             req,
  output ramp_stat_t            stat,
  output logic [DUTY_WIDTH-1:0] duty
);

  localparam int DW   = DUTY_WIDTH;
  localparam int SW   = $clog2(SPEED_LIMIT + 1);
  localparam int SUMW = ((16 + SW > 26) ? 16 + SW : 26) + 2;
  localparam int PW   = SUMW + RATIO_W;
  localparam int LW   = PW - 27;
  localparam int CW   = ((LW > DW) ? LW : DW) + 1;
  localparam int NW   = ((DW > TARGET_W) ? DW : TARGET_W) + 2;

  typedef enum logic [1:0] {R_IDLE, R_MUL1, R_MUL2, R_APPLY} rstate_t;

  rstate_t                   rstate;
  logic                      done;
  logic                      mul_start;
  logic                      mul_sel;
  logic                      mul_done;
  logic signed [SUMW-1:0]    mul_a;
  logic [RATIO_W-1:0]        mul_b;
  logic signed [PW-1:0]      prod;
  logic signed [SUMW-1:0]    sum;
  logic [13:0]               off_sum;

  logic [TARGET_W-1:0]       target_q;
  logic                      restrict_q;
  logic signed [COMP_W-1:0]  comp_q;
  logic [SW-1:0]             speed_q;
  logic                      ge_q;
  logic [CNT_W-1:0]          up_count;
  logic [CNT_W-1:0]          down_count;

  logic [SW-1:0]             speed_clamp;
  logic [LW-1:0]             lim;
  logic signed [CW-1:0]      lim_x;
  logic signed [CW-1:0]      last_x;
  logic                      ge_c;

  logic signed [NW-1:0]      last_n;
  logic signed [NW-1:0]      last_m3;
  logic signed [NW-1:0]      tgt_n;
  logic signed [NW-1:0]      upper_n;
  logic signed [NW-1:0]      lower_n;
  logic signed [NW-1:0]      dmax_n;
  logic signed [NW-1:0]      nxt;
  logic signed [NW-1:0]      clamped;
  logic [DW-1:0]             duty_next;
  logic [CNT_W-1:0]          up_inc;
  logic [CNT_W-1:0]          down_inc;
  logic [CNT_W-1:0]          up_next;
  logic [CNT_W-1:0]          down_next;

  always_comb begin
    if (req.speed[SPEED_W-1]) begin
      speed_clamp = '0;
    end else if (req.speed[SPEED_W-2:0] > 15'(SPEED_LIMIT)) begin
      speed_clamp = SW'(SPEED_LIMIT);
    end else begin
      speed_clamp = SW'(req.speed[SPEED_W-2:0]);
    end
  end

  // gain*speed + (offset + comp) * 4096, then times bus ratio
  assign off_sum = {cfg.duty_offset[12], cfg.duty_offset} + {{2{comp_q[11]}}, comp_q};
  assign sum     = prod[SUMW-1:0] + {{(SUMW-26){off_sum[13]}}, off_sum, 12'd0};
  assign mul_a   = mul_sel ? sum : {{(SUMW-SW){1'b0}}, speed_q};
  assign mul_b   = mul_sel ? cfg.bus_ratio : cfg.speed_gain;

  hcdr_serial_mul #(
    .AW (SUMW),
    .BW (RATIO_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  // floor of the Q.27 product; negative line is below any duty anyway
  assign lim     = prod[PW-1:27];
  assign lim_x   = {{(CW-LW){lim[LW-1]}}, lim};
  assign last_x  = {{(CW-DW){1'b0}}, duty};

  assign last_n  = {{(NW-DW){1'b0}}, duty};
  assign last_m3 = last_n - NW'(RESTRICT_STEP);
  assign tgt_n   = {{(NW-TARGET_W){1'b0}}, target_q};
  assign upper_n = {{(NW-12){1'b0}}, cfg.duty_upper};
  assign lower_n = {{(NW-12){1'b0}}, cfg.duty_lower};
  assign dmax_n  = {{(NW-DW){1'b0}}, {DW{1'b1}}};
  assign ge_c    = (last_n >= tgt_n) || (lim_x <= last_x);

  always_comb begin
    up_inc    = up_count + CNT_W'(1);
    down_inc  = down_count + CNT_W'(1);
    up_next   = up_count;
    down_next = down_count;
    nxt       = last_n;
    if (restrict_q) begin
      nxt = (tgt_n > last_m3) ? last_m3 : tgt_n;
    end else if (ge_q) begin
      if (down_inc > {1'b0, cfg.sub_interval}) begin
        down_next = '0;
        nxt       = last_n - NW'(1);
      end else begin
        down_next = down_inc;
      end
    end else begin
      if (up_inc > {1'b0, cfg.add_interval}) begin
        up_next = '0;
        nxt     = last_n + NW'(1);
      end else begin
        up_next = up_inc;
      end
    end
    if (nxt > upper_n) begin
      clamped = upper_n;
    end else if (nxt < lower_n) begin
      clamped = lower_n;
    end else begin
      clamped = nxt;
    end
    if (clamped[NW-1]) begin
      duty_next = '0;
    end else if (clamped > dmax_n) begin
      duty_next = {DW{1'b1}};
    end else begin
      duty_next = clamped[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate     <= R_IDLE;
      done       <= 1'b0;
      mul_start  <= 1'b0;
      mul_sel    <= 1'b0;
      duty       <= '0;
      up_count   <= '0;
      down_count <= '0;
    end else begin
      done      <= (rstate == R_APPLY);
      mul_start <= ((rstate == R_IDLE) && start && !req.restrict_on) ||
                   ((rstate == R_MUL1) && mul_done);
      unique case (rstate)
        R_IDLE: begin
          if (start) begin
            target_q   <= req.target;
            restrict_q <= req.restrict_on;
            comp_q     <= req.comp;
            speed_q    <= speed_clamp;
            mul_sel    <= 1'b0;
            if (req.restrict_on) begin
              rstate <= R_APPLY;
            end else begin
              rstate <= R_MUL1;
            end
          end
        end
        R_MUL1: begin
          if (mul_done) begin
            mul_sel <= 1'b1;
            rstate  <= R_MUL2;
          end
        end
        R_MUL2: begin
          if (mul_done) begin
            ge_q   <= ge_c;
            rstate <= R_APPLY;
          end
        end
        R_APPLY: begin
          duty       <= duty_next;
          up_count   <= up_next;
          down_count <= down_next;
          rstate     <= R_IDLE;
        end
        default: rstate <= R_IDLE;
      endcase
    end
  end

  assign stat.busy = (rstate != R_IDLE);
  assign stat.done = done;

endmodule

/* design/hall_commutation_duty_ramp.sv */
// When running, a result waits on two 8-step radix-4 multiplies on the
// shared serial multiplier; restrict mode skips both, and with run off the
// ramp is not started. A new request is taken the cycle after the result is
// loaded; in_stall holds off requests until then.
// Reset (synchronous) clears the hall position, duty, ramp counters and
// handshake state, and loads the register defaults.
// ----------------------------------------------------------------------------
// hall_commutation_duty_ramp
// Six-step hall commutation with a speed-limited duty ramp, one request per
// PWM period.
// ----------------------------------------------------------------------------
module hall_commutation_duty_ramp import hcdr_pkg::*; #(
  parameter int DUTY_WIDTH  = 12,
  parameter int SPEED_LIMIT = 6000
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                hall_bits,
  input  logic [TARGET_W-1:0]       target_duty,
  input  logic signed [SPEED_W-1:0] motor_speed,
  input  logic                      restrict_mode,
  input  logic signed [COMP_W-1:0]  current_comp,
  input  logic                      run_enable,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [5:0]                gate_mask,
  output logic [1:0]                high_phase,
  output logic [1:0]                low_phase,
  output logic [DUTY_OUT_W-1:0]     duty_out,
  output logic                      hall_error,
  output logic                      sequence_error,
  output logic [2:0]                hall_position
);

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DONE} state_t;

  state_t                state;
  cfg_t                  cfg;
  hall_t                 hall_now;
  logic                  ramp_start;
  ramp_req_t             ramp_req;
  ramp_stat_t            ramp_stat;
  logic [DUTY_WIDTH-1:0] ramp_duty;

  gates_t                p_gates;
  phase_t                p_hp;
  phase_t                p_lp;
  logic                  p_herr;
  logic                  p_serr;
  hall_t                 p_pos;

  logic                  hall_err_c;
  logic                  seq_ok_c;
  logic                  seq_err_c;
  phase_t                hp_c;
  phase_t                lp_c;
  gates_t                gates_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.add_interval <= ADD_INTERVAL_RST;
      cfg.sub_interval <= SUB_INTERVAL_RST;
      cfg.duty_upper   <= DUTY_UPPER_RST;
      cfg.duty_lower   <= DUTY_LOWER_RST;
      cfg.speed_gain   <= SPEED_GAIN_RST;
      cfg.duty_offset  <= DUTY_OFFSET_RST;
      cfg.bus_ratio    <= BUS_RATIO_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADD_INTERVAL: cfg.add_interval <= cfg_data[7:0];
        REG_SUB_INTERVAL: cfg.sub_interval <= cfg_data[7:0];
        REG_DUTY_UPPER:   cfg.duty_upper   <= cfg_data[11:0];
        REG_DUTY_LOWER:   cfg.duty_lower   <= cfg_data[11:0];
        REG_SPEED_GAIN:   cfg.speed_gain   <= cfg_data;
        REG_DUTY_OFFSET:  cfg.duty_offset  <= $signed(cfg_data[12:0]);
        REG_BUS_RATIO:    cfg.bus_ratio    <= cfg_data;
        default: ;
      endcase
    end
  end

  // commutation from the incoming code against the stored position
  always_comb begin
    hall_err_c = (hall_bits == HALL_ALL_LOW) || (hall_bits == HALL_ALL_HIGH);
    seq_ok_c   = (hall_now == hall_bits) || (hall_now == PRED_OF[hall_bits]);
    hp_c       = PHASE_NONE;
    lp_c       = PHASE_NONE;
    gates_c    = '0;
    seq_err_c  = 1'b0;
    if (run_enable && !hall_err_c) begin
      if (seq_ok_c) begin
        hp_c    = HI_OF[hall_bits];
        lp_c    = LO_OF[hall_bits];
        gates_c = gate_pattern(HI_OF[hall_bits], LO_OF[hall_bits]);
      end else begin
        seq_err_c = 1'b1;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      ramp_start <= 1'b0;
      hall_now   <= '0;
    end else begin
      ramp_start <= (state == ST_IDLE) && in_valid && run_enable;
      if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            hall_now             <= hall_bits;
            p_gates              <= gates_c;
            p_hp                 <= hp_c;
            p_lp                 <= lp_c;
            p_herr               <= hall_err_c;
            p_serr               <= seq_err_c;
            p_pos                <= hall_bits;
            ramp_req.target      <= target_duty;
            ramp_req.speed       <= motor_speed;
            ramp_req.restrict_on <= restrict_mode;
            ramp_req.comp        <= current_comp;
            if (run_enable) begin
              state <= ST_BUSY;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_BUSY: begin
          if (ramp_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            gate_mask      <= p_gates;
            high_phase     <= p_hp;
            low_phase      <= p_lp;
            duty_out       <= DUTY_OUT_W'(ramp_duty);
            hall_error     <= p_herr;
            sequence_error <= p_serr;
            hall_position  <= p_pos;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  hcdr_ramp #(
    .DUTY_WIDTH  (DUTY_WIDTH),
    .SPEED_LIMIT (SPEED_LIMIT)
  ) u_ramp (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (ramp_start),
    .req   (ramp_req),
    .stat  (ramp_stat),
    .duty  (ramp_duty)
  );

`ifndef ASSERT_OFF
  a_idle_ramp_quiet: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !ramp_stat.busy)
    else $error("ramp busy while taking requests");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    ramp_stat.done |-> (state == ST_BUSY))
    else $error("ramp finished with no request outstanding");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    ramp_start |=> ramp_stat.busy)
    else $error("ramp ignored start");

  a_two_gates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (gate_mask != '0)) |->
      (($countones(gate_mask) == 2) && (high_phase != PHASE_NONE)))
    else $error("gate pattern not one high and one low switch");

  a_error_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (hall_error || sequence_error)) |-> (gate_mask == '0))
    else $error("gates on during hall fault");
`endif

endmodule
